FILE: rtl/assert_macros.svh
// Assertion macros used by the checker of the APV event parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/apv_pkg.sv
// Types and constants of the APV ADC event word parser.
// No dependencies; used by the top level and its checker.
`default_nettype none

package apv_pkg;

    localparam int unsigned POS_W = 18;
    localparam logic [POS_W-1:0] POS_TOP = '1;

    localparam logic [28:0] TS_GEO = 29'h1000_0000;
    localparam int unsigned ADC_W = 14;

    localparam logic [31:0] START_MARK = 32'h0001_0002;
    localparam logic [31:0] STOP_MARK  = 32'h0001_0003;
    localparam logic [15:0] CLOCK_MARK = 16'h0aaa;
    localparam logic [15:0] STAMP_MARK = 16'h1bbb;
    localparam logic [31:0] MIN_BYTES  = 32'd64;
    localparam logic [31:0] LEN_SLACK  = 32'd14;

    typedef struct packed {
        logic [31:0] raw_word;
        logic        first_word;
        logic [31:0] event_bytes;
    } t_in_item;

    typedef struct packed {
        logic [28:0] geo;
        logic [6:0]  chan;
        logic [31:0] value;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/apv_adc_event_word_parser.sv
// APV ADC event word parser: input register, one decode step, result register.
// A word is registered in the input register, its result in the result
// register, from which it can transfer. Throughput: one word per cycle unless
// the sink holds back a result; one decode step between the two registers.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parse state to "no event": words before the first first_word give nothing.
// Depends on apv_pkg.
`default_nettype none

module apv_adc_event_word_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire apv_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output apv_pkg::t_out_item     o_out_data
);

    // Fixed word positions of the event layout (after the board one offset a).
    localparam logic [18:0] POS_MARK   = 19'd2;
    localparam logic [18:0] POS_B1_HDR = 19'd12;
    localparam logic [18:0] OFS_B1     = 19'd13;
    localparam logic [18:0] OFS_CLK0   = 19'd14;
    localparam logic [18:0] OFS_CLK1   = 19'd15;
    localparam logic [18:0] OFS_STP0   = 19'd16;
    localparam logic [18:0] OFS_STP1   = 19'd17;
    localparam logic [18:0] OFS_B2_HDR = 19'd19;
    localparam logic [18:0] OFS_B2     = 19'd20;

    // Input register
    logic              r_in_valid;
    apv_pkg::t_in_item r_in;

    // Result register
    logic               r_out_valid;
    apv_pkg::t_out_item r_out;

    // Parse state
    logic [apv_pkg::POS_W-1:0] r_word_pos, n_word_pos;
    logic [31:0] r_bytes_held, n_bytes_held;
    logic [15:0] r_board_one_len, n_board_one_len;
    logic [15:0] r_board_two_len, n_board_two_len;
    logic [15:0] r_block_len, n_block_len;
    logic [15:0] r_block_done, n_block_done;
    logic        r_drop_event, n_drop_event;
    logic        r_clock_seen, n_clock_seen;
    logic        r_stamp_seen, n_stamp_seen;

    logic               out_blocked;
    logic               advance;
    logic               hit;
    apv_pkg::t_out_item res;

    // Decode temporaries
    logic [apv_pkg::POS_W-1:0] p;
    logic [18:0] pw, aw, bw;
    logic [31:0] w;
    logic [15:0] done_inc;
    logic        skip;
    logic        in_b1, in_b2;

    // A finished result that the sink holds back freezes the decode stage;
    // the input register then stalls only if it already holds a word.
    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        // First word restarts the event; otherwise carry the held state.
        if (r_in.first_word) begin
            n_bytes_held    = r_in.event_bytes;
            n_board_one_len = '0;
            n_board_two_len = '0;
            n_block_len     = '0;
            n_block_done    = '0;
            n_clock_seen    = 1'b0;
            n_stamp_seen    = 1'b0;
            n_drop_event    = r_in.event_bytes < apv_pkg::MIN_BYTES;
            p               = '0;
        end else begin
            n_bytes_held    = r_bytes_held;
            n_board_one_len = r_board_one_len;
            n_board_two_len = r_board_two_len;
            n_block_len     = r_block_len;
            n_block_done    = r_block_done;
            n_clock_seen    = r_clock_seen;
            n_stamp_seen    = r_stamp_seen;
            n_drop_event    = r_drop_event;
            p               = r_word_pos;
        end

        n_word_pos = (p == apv_pkg::POS_TOP) ? apv_pkg::POS_TOP
                                             : p + {{(apv_pkg::POS_W-1){1'b0}}, 1'b1};

        // Dropped event, past the event end, or saturated position: no effect.
        skip = n_drop_event || ({14'd0, p} >= {2'd0, n_bytes_held[31:2]}) ||
               (p == apv_pkg::POS_TOP);

        w  = {r_in.raw_word[7:0], r_in.raw_word[15:8],
              r_in.raw_word[23:16], r_in.raw_word[31:24]};
        pw = {1'b0, p};
        aw = {3'd0, n_board_one_len};
        bw = {3'd0, n_board_two_len};

        in_b1 = (pw >= OFS_B1) && (pw < OFS_B1 + aw);
        in_b2 = (pw >= OFS_B2 + aw) && (pw < OFS_B2 + aw + bw);

        done_inc = n_block_done + 16'd1;
        hit      = 1'b0;
        res.geo  = apv_pkg::TS_GEO;
        res.chan = '0;
        res.value = w;

        if (!skip) begin
            if (pw == POS_MARK) begin
                if (r_in.raw_word == apv_pkg::START_MARK ||
                    r_in.raw_word == apv_pkg::STOP_MARK) begin
                    n_drop_event = 1'b1;
                end
            end else if (pw == POS_B1_HDR) begin
                // Board one word count checked against a byte count, as specified.
                if ({16'd0, w[31:16]} > n_bytes_held - apv_pkg::LEN_SLACK) begin
                    n_drop_event = 1'b1;
                end else begin
                    n_board_one_len = w[31:16];
                    n_block_len     = '0;
                    n_block_done    = '0;
                end
            end else if (pw < POS_B1_HDR) begin
                hit = 1'b0;
            end else if (in_b1 || in_b2) begin
                if (n_block_len == 16'd0) begin
                    // block header: high half is the data word count
                    n_block_done = '0;
                    n_block_len  = w[31:16];
                end else begin
                    hit       = !w[31];
                    res.geo   = {2'd0, w[30:28], 5'd0, w[27:25], 12'd0, w[24:21]};
                    res.chan  = w[20:14];
                    res.value = {18'd0, w[apv_pkg::ADC_W-1:0]};
                    n_block_done = done_inc;
                    if (done_inc == n_block_len) begin
                        n_block_len = '0;
                    end
                end
            end else if (pw == OFS_CLK0 + aw) begin
                n_clock_seen = (w[31:16] == apv_pkg::CLOCK_MARK);
                hit          = n_clock_seen;
                res.chan     = 7'd0;
                res.value    = {16'd0, w[15:0]};
            end else if (pw == OFS_CLK1 + aw) begin
                hit      = n_clock_seen;
                res.chan = 7'd1;
            end else if (pw == OFS_STP0 + aw) begin
                n_stamp_seen = (w[31:16] == apv_pkg::STAMP_MARK);
                hit          = n_stamp_seen;
                res.chan     = 7'd2;
                res.value    = {16'd0, w[15:0]};
            end else if (pw == OFS_STP1 + aw) begin
                hit      = n_stamp_seen;
                res.chan = 7'd3;
            end else if (pw == OFS_B2_HDR + aw) begin
                n_board_two_len = w[31:16];
                n_block_len     = '0;
                n_block_done    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_word_pos      <= '0;
            r_bytes_held    <= '0;
            r_board_one_len <= '0;
            r_board_two_len <= '0;
            r_block_len     <= '0;
            r_block_done    <= '0;
            r_drop_event    <= 1'b1;
            r_clock_seen    <= 1'b0;
            r_stamp_seen    <= 1'b0;
        end else begin
            // Input register loads whenever it is not stalled.
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            // Result register: refill or empty whenever the sink is not holding it.
            if (!out_blocked) begin
                r_out_valid <= advance && hit;
            end
            if (advance) begin
                r_word_pos      <= n_word_pos;
                r_bytes_held    <= n_bytes_held;
                r_board_one_len <= n_board_one_len;
                r_board_two_len <= n_board_two_len;
                r_block_len     <= n_block_len;
                r_block_done    <= n_block_done;
                r_drop_event    <= n_drop_event;
                r_clock_seen    <= n_clock_seen;
                r_stamp_seen    <= n_stamp_seen;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance && hit) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/apv_checker.sv
// Port-level checker of the APV ADC event word parser, bound to the top level.
// Depends on apv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module apv_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire apv_pkg::t_out_item o_out_data
);

    // A held result stays offered.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // Input stalls only while a result is held back at the output.
    `ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // Timestamp records use slots 0 to 3 only.
    `ASSERT_IMP(a_ts_slot, i_clk, i_rst_n,
        o_out_valid && o_out_data.geo == apv_pkg::TS_GEO, o_out_data.chan[6:2] == 5'd0)

    // Data results carry a 14-bit ADC and a geo with only sector, module, apv bits.
    `ASSERT_IMP(a_adc_range, i_clk, i_rst_n,
        o_out_valid && o_out_data.geo != apv_pkg::TS_GEO,
        o_out_data.value[31:14] == 18'd0 && o_out_data.geo[23:19] == 5'd0 &&
        o_out_data.geo[15:4] == 12'd0 && o_out_data.geo[28:27] == 2'd0)

endmodule

bind apv_adc_event_word_parser apv_checker u_apv_checker (.*);

`default_nettype wire

FILE: tb/apv_adc_event_word_parser_tb.sv
// Self-checking bench for apv_adc_event_word_parser: builds APV events, predicts records.
// Depends on apv_pkg and the parser RTL; no files, plusargs or seeds are read.

module apv_adc_event_word_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Timestamp slot codes carried on the chan field of timestamp records.
    localparam logic [6:0] SLOT_CLOCK_LO = 7'd0;
    localparam logic [6:0] SLOT_CLOCK    = 7'd1;
    localparam logic [6:0] SLOT_STAMP_LO = 7'd2;
    localparam logic [6:0] SLOT_STAMP    = 7'd3;

    localparam int QUIET_LIMIT = 5000;  // cycles with no transfer on either side
    localparam int LONG_HOLD   = 300;   // receiver hold-off for the back-pressure test
    localparam int DRAIN_LIMIT = 2000;
    localparam int END_SETTLE  = 8;     // settle time past the parser latency
    localparam int PHASE_WORDS = 260;

    function automatic logic [31:0] byte_swap(input logic [31:0] x);
        return {<<8{x}};
    endfunction

    // ------------------------------------------------------------------
    // Record book: tracks the event parse state word by word and keeps the
    // records that the parser still owes, oldest first.
    // ------------------------------------------------------------------
    class adc_record_book;
        int unsigned next_pos;
        logic [31:0] evt_bytes;
        logic [15:0] len_one;
        logic [15:0] len_two;
        logic [15:0] blk_words;   // 0: next block word is a header
        logic [15:0] blk_seen;
        bit          skip_event;
        bit          clock_hit;
        bit          stamp_hit;
        apv_pkg::t_out_item owed[$];
        int          mismatches;

        function new();
            next_pos   = 0;
            evt_bytes  = '0;
            len_one    = '0;
            len_two    = '0;
            blk_words  = '0;
            blk_seen   = '0;
            skip_event = 1'b1;   // nothing is parsed before the first word mark
            clock_hit  = 1'b0;
            stamp_hit  = 1'b0;
            mismatches = 0;
        endfunction

        function int waiting();
            return owed.size();
        endfunction

        function void add_record(logic [28:0] geo, logic [6:0] chan, logic [31:0] value);
            apv_pkg::t_out_item rec;
            rec.geo   = geo;
            rec.chan  = chan;
            rec.value = value;
            owed.push_back(rec);
        endfunction

        // One word of a length-headed block: header or data word.
        function void block_word(logic [31:0] w);
            logic [28:0] geo;
            if (blk_words == 0) begin
                blk_seen  = '0;
                blk_words = w[31:16];
                return;
            end
            if (!w[31]) begin
                geo = '0;
                geo[26:24] = w[30:28];   // sector
                geo[18:16] = w[27:25];   // module
                geo[3:0]   = w[24:21];   // apv
                add_record(geo, w[20:14], {18'h0, w[13:0]});
            end
            blk_seen = blk_seen + 16'd1;
            if (blk_seen == blk_words)
                blk_words = '0;
        endfunction

        function void note_word(apv_pkg::t_in_item it);
            int unsigned p;
            int unsigned a;
            int unsigned b;
            logic [31:0] w;
            if (it.first_word) begin
                evt_bytes  = it.event_bytes;
                len_one    = '0;
                len_two    = '0;
                blk_words  = '0;
                blk_seen   = '0;
                clock_hit  = 1'b0;
                stamp_hit  = 1'b0;
                skip_event = (it.event_bytes < apv_pkg::MIN_BYTES);
                p = 0;
            end else begin
                p = next_pos;
            end
            next_pos = (p >= apv_pkg::POS_TOP) ? apv_pkg::POS_TOP : p + 1;

            if (skip_event || p >= (evt_bytes >> 2) || p >= apv_pkg::POS_TOP)
                return;

            w = byte_swap(it.raw_word);
            a = {16'd0, len_one};
            b = {16'd0, len_two};

            if (p == 2) begin
                // marker test uses the word as stored
                if (it.raw_word == apv_pkg::START_MARK || it.raw_word == apv_pkg::STOP_MARK)
                    skip_event = 1'b1;
            end else if (p == 12) begin
                // word count against byte count, as the format defines it
                if ({16'd0, w[31:16]} > evt_bytes - apv_pkg::LEN_SLACK) begin
                    skip_event = 1'b1;
                end else begin
                    len_one   = w[31:16];
                    blk_words = '0;
                    blk_seen  = '0;
                end
            end else if (p >= 13 && p < 13 + a) begin
                block_word(w);
            end else if (p == 14 + a) begin
                clock_hit = (w[31:16] == apv_pkg::CLOCK_MARK);
                if (clock_hit)
                    add_record(apv_pkg::TS_GEO, SLOT_CLOCK_LO, {16'h0, w[15:0]});
            end else if (p == 15 + a) begin
                if (clock_hit)
                    add_record(apv_pkg::TS_GEO, SLOT_CLOCK, w);
            end else if (p == 16 + a) begin
                stamp_hit = (w[31:16] == apv_pkg::STAMP_MARK);
                if (stamp_hit)
                    add_record(apv_pkg::TS_GEO, SLOT_STAMP_LO, {16'h0, w[15:0]});
            end else if (p == 17 + a) begin
                if (stamp_hit)
                    add_record(apv_pkg::TS_GEO, SLOT_STAMP, w);
            end else if (p == 19 + a) begin
                len_two   = w[31:16];
                blk_words = '0;
                blk_seen  = '0;
            end else if (p >= 20 + a && p < 20 + a + b) begin
                block_word(w);
            end
        endfunction

        function void check_record(apv_pkg::t_out_item got);
            apv_pkg::t_out_item want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected record geo=%h chan=%h value=%h",
                         $time, got.geo, got.chan, got.value);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (got.geo !== want.geo) begin
                $display("%0t: geo expected %h, got %h", $time, want.geo, got.geo);
                mismatches++;
            end
            if (got.chan !== want.chan) begin
                $display("%0t: chan expected %h, got %h", $time, want.chan, got.chan);
                mismatches++;
            end
            if (got.value !== want.value) begin
                $display("%0t: value expected %h, got %h", $time, want.value, got.value);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the parser
    // ------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    apv_pkg::t_in_item  in_data   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    apv_pkg::t_out_item out_data;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    apv_adc_event_word_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    adc_record_book book;

    // Pacing knobs. idle_pct is read only by the sender; stall_pct and
    // hold_asked cross into the receiver process, so they change by NBA.
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_asked = 0;
    int words_sent = 0;

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted here whenever
    // the stimulus asks for one (hold_asked moves ahead of hold_served).
    // ------------------------------------------------------------------
    int hold_served = 0;
    int hold_left   = 0;

    always @(posedge clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every transfer is seen here with pre-edge values, so the
    // record book never depends on process order within the step.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                book.note_word(in_data);
            if (out_valid && !out_stall)
                book.check_record(out_data);
        end
    end

    // Watchdog: too long without any transfer means the parser hung.
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("apv_adc_event_word_parser verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One word transfer. Called right after an edge; returns right after
    // the edge that accepted the word.
    task automatic push_word(input logic [31:0] raw, input bit first,
                             input logic [31:0] nbytes);
        apv_pkg::t_in_item it;
        it.raw_word    = raw;
        it.first_word  = first;
        it.event_bytes = nbytes;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Event under construction, in byte-swapped (decoded) word order.
    logic [31:0] ev_words[$];

    // Length-headed blocks filling exactly n words; a header may promise
    // more words than remain, and some headers are empty.
    function automatic void fill_blocks(input int n);
        int left;
        int cnt;
        left = n;
        while (left > 0) begin
            cnt = ($urandom_range(7) == 0) ? 0 : $urandom_range(6, 1);
            ev_words.push_back({16'(cnt), 16'($urandom)});
            left--;
            while (cnt > 0 && left > 0) begin
                // debug bit set on about one data word in eight
                ev_words.push_back({1'($urandom_range(7) == 0), 31'($urandom)});
                cnt--;
                left--;
            end
        end
    endfunction

    function automatic void build_event(input int a_len, input int b_len,
                                        input bit clock_ok, input bit stamp_ok);
        ev_words.delete();
        repeat (12) ev_words.push_back($urandom);
        ev_words.push_back({16'(a_len), 16'($urandom)});                    // word 12
        fill_blocks(a_len);
        ev_words.push_back($urandom);                                       // 13+a
        ev_words.push_back(clock_ok ? {apv_pkg::CLOCK_MARK, 16'($urandom)} : $urandom);
        ev_words.push_back($urandom);                                       // 15+a
        ev_words.push_back(stamp_ok ? {apv_pkg::STAMP_MARK, 16'($urandom)} : $urandom);
        ev_words.push_back($urandom);                                       // 17+a
        ev_words.push_back($urandom);                                       // 18+a
        ev_words.push_back({16'(b_len), 16'($urandom)});                    // 19+a
        fill_blocks(b_len);
    endfunction

    // event_bytes only matters with the first word; later words carry noise.
    task automatic send_event(input logic [31:0] nbytes);
        foreach (ev_words[i])
            push_word(byte_swap(ev_words[i]), i == 0, (i == 0) ? nbytes : $urandom);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(8, 1))
            push_word($urandom, $urandom_range(15) == 0, $urandom);
    endtask

    // Mostly well-formed events with random content; a share of them hit the
    // drop conditions, get cut short, or are followed by stray words.
    task automatic random_event();
        int a_len;
        int b_len;
        int kind;
        logic [31:0] nbytes;
        a_len = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(30);
        b_len = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(30);
        build_event(a_len, b_len, $urandom_range(9) != 0, $urandom_range(9) != 0);
        nbytes = 32'(ev_words.size() * 4);
        kind = $urandom_range(99);
        if (kind < 5) begin
            ev_words[2] = byte_swap($urandom_range(1) ? apv_pkg::START_MARK
                                                      : apv_pkg::STOP_MARK);
        end else if (kind < 9) begin
            ev_words[12][31:16] = 16'(nbytes - apv_pkg::LEN_SLACK + $urandom_range(200, 1));
        end else if (kind < 11) begin
            ev_words[12][31:16] = 16'(nbytes - apv_pkg::LEN_SLACK);
        end else if (kind < 16) begin
            nbytes = $urandom_range(63);
        end else if (kind < 30) begin
            nbytes = $urandom_range(nbytes, 64);
        end else if (kind < 40) begin
            nbytes = nbytes + $urandom_range(400, 1);
        end
        send_event(nbytes);
        if (kind >= 40 && kind < 50)
            repeat ($urandom_range(6, 1))
                push_word($urandom, 1'b0, $urandom);
    endtask

    // Sender stops until every owed record has come back or the drain limit runs out.
    task automatic drain();
        int spent;
        spent = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.waiting() != 0 && spent < DRAIN_LIMIT) begin
            @(posedge clk);
            spent++;
        end
    endtask

    task automatic set_pace(input int idle, input int stall);
        idle_pct = idle;
        stall_pct <= stall;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int target;
        book = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side.
        set_pace(0, 0);

        // Words before any event start are ignored.
        repeat (3) push_word($urandom, 1'b0, $urandom);

        // Short event: under 64 bytes drops everything.
        build_event(1, 1, 1'b1, 1'b1);
        send_event(32'd63);

        // Start and stop markers in word 2 drop the event.
        build_event(2, 2, 1'b1, 1'b1);
        ev_words[2] = byte_swap(apv_pkg::START_MARK);
        send_event(32'(ev_words.size() * 4));
        build_event(2, 2, 1'b1, 1'b1);
        ev_words[2] = byte_swap(apv_pkg::STOP_MARK);
        send_event(32'(ev_words.size() * 4));

        // Board one length right at the limit is kept, one more is dropped.
        build_event(0, 0, 1'b1, 1'b1);
        ev_words[12][31:16] = 16'd50;
        send_event(32'd64);
        build_event(0, 0, 1'b1, 1'b1);
        ev_words[12][31:16] = 16'd51;
        send_event(32'd64);

        // Field extremes, an empty header, debug words, odd byte count.
        build_event(4, 3, 1'b1, 1'b1);
        ev_words[13] = {16'd2, 16'hffff};
        ev_words[14] = 32'h7fff_ffff;
        ev_words[15] = 32'h0000_0000;
        ev_words[16] = {16'd0, 16'h1234};
        ev_words[18] = {apv_pkg::CLOCK_MARK, 16'hffff};
        ev_words[19] = 32'hffff_ffff;
        ev_words[20] = {apv_pkg::STAMP_MARK, 16'h0000};
        ev_words[21] = 32'h0000_0000;
        ev_words[24] = {16'd2, 16'h0000};
        ev_words[25] = 32'hffff_ffff;
        ev_words[26] = 32'h0000_4000;
        send_event(32'(ev_words.size() * 4 + 3));

        // Only one of the two timestamp markers present.
        build_event(2, 2, 1'b0, 1'b1);
        send_event(32'(ev_words.size() * 4));
        build_event(2, 2, 1'b1, 1'b0);
        send_event(32'(ev_words.size() * 4));

        // Event byte count ends inside board one; the rest is past the end.
        build_event(10, 10, 1'b1, 1'b1);
        send_event(32'd66);

        // Long event: byte count far beyond the words that follow.
        build_event(3, 3, 1'b1, 1'b1);
        send_event(32'hffff_ffff);
        drain();

        // Random part in four pacing phases.
        target = words_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_pace(0, 0);
                1: set_pace(70, 0);
                2: set_pace(0, 70);
                default: set_pace(25, 25);
            endcase
            target += PHASE_WORDS;
            if (phase == 2) begin
                // Long receiver hold-off while a dense event keeps coming:
                // the parser fills up and must stall its input.
                idle_pct = 0;
                hold_asked <= hold_asked + 1;
                build_event(40, 40, 1'b1, 1'b1);
                send_event(32'(ev_words.size() * 4));
                idle_pct = 0;
            end
            while (words_sent < target) begin
                if ($urandom_range(9) == 0)
                    noise_burst();
                else
                    random_event();
            end
            drain();
        end

        drain();
        repeat (END_SETTLE) @(posedge clk);
        if (book.waiting() != 0)
            $display("%0t: %0d expected records never arrived", $time, book.waiting());
        if (book.mismatches == 0 && book.waiting() == 0) begin
            $display("apv_adc_event_word_parser verification clean");
        end else begin
            $display("apv_adc_event_word_parser verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/apv_pkg.sv
rtl/apv_adc_event_word_parser.sv
rtl/apv_checker.sv
tb/apv_adc_event_word_parser_tb.sv
